[sv/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, sampled on the rising clock, off during reset.
`define CHK_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

// Implication into the next cycle.
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

`endif

[sv/rrts_pkg.sv]
// ----------------------------------------------------------------------------
// rrts_pkg
// Types, codes and sizes shared by the round-robin task scheduler files.
// ----------------------------------------------------------------------------
package rrts_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS    = PTR_BITS + 1;
   localparam int ID_BITS     = 8;
   localparam logic [7:0] ID_MASK = 8'((1 << ID_BITS) - 1);

   // event kinds
   localparam logic [2:0] KIND_CREATE   = 3'd0;
   localparam logic [2:0] KIND_DISPATCH = 3'd1;
   localparam logic [2:0] KIND_TIMEOUT  = 3'd2;
   localparam logic [2:0] KIND_OCCUR    = 3'd3;
   localparam logic [2:0] KIND_WAIT     = 3'd4;

   // result status
   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_NO_READY     = 3'd1;
   localparam logic [2:0] ST_ALREADY_RUN  = 3'd2;
   localparam logic [2:0] ST_NONE_RUNNING = 3'd3;
   localparam logic [2:0] ST_NONE_BLOCKED = 3'd4;
   localparam logic [2:0] ST_QUEUE_FULL   = 3'd5;

   // register indexes
   localparam logic CSR_QUANTUM   = 1'b0;
   localparam logic CSR_MEM_TOTAL = 1'b1;

   localparam logic [7:0]  QUANTUM_RESET   = 8'd2;
   localparam logic [15:0] MEM_TOTAL_RESET = 16'd100;

   // datapath operations
   localparam logic [3:0] OP_NONE     = 4'd0;
   localparam logic [3:0] OP_CAPTURE  = 4'd1;
   localparam logic [3:0] OP_CREATE   = 4'd2;
   localparam logic [3:0] OP_DISPATCH = 4'd3;
   localparam logic [3:0] OP_RELEASE  = 4'd4;
   localparam logic [3:0] OP_ROTATE   = 4'd5;
   localparam logic [3:0] OP_WAKE     = 4'd6;
   localparam logic [3:0] OP_BLOCK    = 4'd7;
   localparam logic [3:0] OP_ADMIT    = 4'd8;

   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] size;
      logic [15:0] left;
   } task_type;

   typedef struct packed {
      logic [3:0] op;
      logic       set_status;
      logic [2:0] status;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       new_full;
      logic       ready_empty;
      logic       ready_full;
      logic       blocked_empty;
      logic       blocked_full;
      logic       running;
      logic       finish;
      logic       can_admit;
   } dp_stat_type;

   function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
      logic [PTR_BITS-1:0] r;
      if (p == PTR_BITS'(QUEUE_DEPTH - 1)) r = '0;
      else r = p + PTR_BITS'(1);
      return r;
   endfunction

   function automatic logic [PTR_BITS-1:0] ptr_add(input logic [PTR_BITS-1:0] p,
                                                   input logic [CNT_BITS-1:0] c);
      logic [CNT_BITS-1:0] s;
      s = {1'b0, p} + c;
      if (s >= CNT_BITS'(QUEUE_DEPTH)) s = s - CNT_BITS'(QUEUE_DEPTH);
      return s[PTR_BITS-1:0];
   endfunction

endpackage

[sv/rrts_ctrl.sv]
// ----------------------------------------------------------------------------
// rrts_ctrl
// Event sequencer: capture, execute, admission walk, result beat.
// ----------------------------------------------------------------------------
module rrts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   input  rrts_pkg::dp_stat_type stat,
   output rrts_pkg::dp_cmd_type  cmd
);
   import rrts_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EXEC  = 2'd1;
   localparam logic [1:0] S_ADMIT = 2'd2;
   localparam logic [1:0] S_RESP  = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '{op: OP_NONE, set_status: 1'b0, status: ST_OK};
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_CAPTURE;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
            case (stat.kind)
               KIND_CREATE: begin
                  if (stat.new_full) begin
                     cmd.set_status = 1'b1; cmd.status = ST_QUEUE_FULL;
                  end else begin
                     cmd.op = OP_CREATE; state_in = S_ADMIT;
                  end
               end
               KIND_DISPATCH: begin
                  if (stat.ready_empty) begin
                     cmd.set_status = 1'b1; cmd.status = ST_NO_READY;
                  end else if (stat.running) begin
                     cmd.set_status = 1'b1; cmd.status = ST_ALREADY_RUN;
                  end else cmd.op = OP_DISPATCH;
               end
               KIND_TIMEOUT: begin
                  if (!stat.running) begin
                     cmd.set_status = 1'b1; cmd.status = ST_NONE_RUNNING;
                  end else if (stat.finish) begin
                     cmd.op = OP_RELEASE; state_in = S_ADMIT;
                  end else cmd.op = OP_ROTATE;
               end
               KIND_OCCUR: begin
                  if (stat.blocked_empty) begin
                     cmd.set_status = 1'b1; cmd.status = ST_NONE_BLOCKED;
                  end else if (stat.ready_full) begin
                     cmd.set_status = 1'b1; cmd.status = ST_QUEUE_FULL;
                  end else cmd.op = OP_WAKE;
               end
               KIND_WAIT: begin
                  if (!stat.running) begin
                     cmd.set_status = 1'b1; cmd.status = ST_NONE_RUNNING;
                  end else if (stat.blocked_full) begin
                     cmd.set_status = 1'b1; cmd.status = ST_QUEUE_FULL;
                  end else cmd.op = OP_BLOCK;
               end
               default: ;
            endcase
         end
         S_ADMIT: begin
            if (stat.can_admit) cmd.op = OP_ADMIT;
            else state_in = S_RESP;
         end
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

[sv/rrts_datapath.sv]
// ----------------------------------------------------------------------------
// rrts_datapath
// Task queues, running slot, free memory, registers and result fields.
// ----------------------------------------------------------------------------
module rrts_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  rrts_pkg::dp_cmd_type  cmd,
   output rrts_pkg::dp_stat_type stat,
   input  logic [2:0]           req_kind,
   input  logic [7:0]           req_task_id,
   input  logic [15:0]          req_task_size,
   input  logic [15:0]          req_task_time,
   input  logic                 csr_we,
   input  logic                 csr_addr,
   input  logic [15:0]          csr_wdata,
   output logic [2:0]           rsp_status,
   output logic                 rsp_running_valid,
   output logic [7:0]           rsp_running_id,
   output logic                 rsp_released_valid,
   output logic [7:0]           rsp_released_id,
   output logic [15:0]          rsp_memory_free,
   output logic [4:0]           rsp_admitted_count
);
   import rrts_pkg::*;

   task_type new_mem_ff [QUEUE_DEPTH];
   task_type rdy_mem_ff [QUEUE_DEPTH];
   task_type blk_mem_ff [QUEUE_DEPTH];

   logic [PTR_BITS-1:0] new_head_ff, new_head_in, rdy_head_ff, rdy_head_in;
   logic [PTR_BITS-1:0] blk_head_ff, blk_head_in;
   logic [CNT_BITS-1:0] new_cnt_ff, new_cnt_in, rdy_cnt_ff, rdy_cnt_in;
   logic [CNT_BITS-1:0] blk_cnt_ff, blk_cnt_in;

   task_type   run_ff, run_in, req_ff, req_in;
   logic       run_valid_ff, run_valid_in;
   logic [2:0] kind_ff, kind_in;
   logic [15:0] free_ff, free_in;
   logic [7:0]  quantum_ff, quantum_in;
   logic [2:0]  status_ff, status_in;
   logic        rel_valid_ff, rel_valid_in;
   logic [7:0]  rel_id_ff, rel_id_in;
   logic [4:0]  adm_ff, adm_in;

   logic     new_we, rdy_we, blk_we;
   task_type new_wd, rdy_wd, blk_wd, rot;
   task_type new_head, rdy_head, blk_head;
   logic [PTR_BITS-1:0] new_tail, rdy_tail, blk_tail;
   logic [16:0] rel_sum;

   assign new_head = new_mem_ff[new_head_ff];
   assign rdy_head = rdy_mem_ff[rdy_head_ff];
   assign blk_head = blk_mem_ff[blk_head_ff];
   assign new_tail = ptr_add(new_head_ff, new_cnt_ff);
   assign rdy_tail = ptr_add(rdy_head_ff, rdy_cnt_ff);
   assign blk_tail = ptr_add(blk_head_ff, blk_cnt_ff);
   assign rel_sum  = {1'b0, free_ff} + {1'b0, run_ff.size};

   always_comb begin
      new_head_in = new_head_ff; new_cnt_in = new_cnt_ff;
      rdy_head_in = rdy_head_ff; rdy_cnt_in = rdy_cnt_ff;
      blk_head_in = blk_head_ff; blk_cnt_in = blk_cnt_ff;
      run_in = run_ff; run_valid_in = run_valid_ff;
      req_in = req_ff; kind_in = kind_ff;
      free_in = free_ff; quantum_in = quantum_ff;
      status_in = status_ff; rel_valid_in = rel_valid_ff; rel_id_in = rel_id_ff;
      adm_in = adm_ff;
      new_we = 1'b0; rdy_we = 1'b0; blk_we = 1'b0;
      new_wd = req_ff; rdy_wd = new_head; blk_wd = run_ff;
      rot = run_ff;
      rot.left = run_ff.left - {8'd0, quantum_ff};

      case (cmd.op)
         OP_CAPTURE: begin
            kind_in = req_kind;
            req_in  = '{id: req_task_id & ID_MASK, size: req_task_size,
                        left: req_task_time};
            status_in = ST_OK; rel_valid_in = 1'b0; rel_id_in = '0; adm_in = '0;
         end
         OP_CREATE: begin
            new_we = 1'b1; new_cnt_in = new_cnt_ff + CNT_BITS'(1);
         end
         OP_DISPATCH: begin
            run_in = rdy_head; run_valid_in = 1'b1;
            rdy_head_in = ptr_inc(rdy_head_ff); rdy_cnt_in = rdy_cnt_ff - CNT_BITS'(1);
         end
         OP_RELEASE, OP_BLOCK: begin
            if (cmd.op == OP_RELEASE) begin
               free_in = rel_sum[16] ? 16'hFFFF : rel_sum[15:0];
               rel_valid_in = 1'b1; rel_id_in = run_ff.id;
            end else begin
               blk_we = 1'b1; blk_cnt_in = blk_cnt_ff + CNT_BITS'(1);
            end
            if (rdy_cnt_ff != '0) begin
               run_in = rdy_head; run_valid_in = 1'b1;
               rdy_head_in = ptr_inc(rdy_head_ff);
               rdy_cnt_in = rdy_cnt_ff - CNT_BITS'(1);
            end else begin
               run_in = '0; run_valid_in = 1'b0;
            end
         end
         OP_ROTATE: begin
            if (rdy_cnt_ff != '0) begin
               // old head runs, charged task goes to the tail; count unchanged
               run_in = rdy_head; rdy_we = 1'b1; rdy_wd = rot;
               rdy_head_in = ptr_inc(rdy_head_ff);
            end else run_in = rot;
         end
         OP_WAKE: begin
            rdy_we = 1'b1; rdy_wd = blk_head; rdy_cnt_in = rdy_cnt_ff + CNT_BITS'(1);
            blk_head_in = ptr_inc(blk_head_ff); blk_cnt_in = blk_cnt_ff - CNT_BITS'(1);
         end
         OP_ADMIT: begin
            rdy_we = 1'b1; rdy_wd = new_head; rdy_cnt_in = rdy_cnt_ff + CNT_BITS'(1);
            new_head_in = ptr_inc(new_head_ff); new_cnt_in = new_cnt_ff - CNT_BITS'(1);
            free_in = free_ff - new_head.size;
            adm_in = adm_ff + 5'd1;
         end
         default: ;
      endcase

      if (cmd.set_status) status_in = cmd.status;

      if (csr_we) begin
         if (csr_addr == CSR_QUANTUM) quantum_in = csr_wdata[7:0];
         else free_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (new_we) new_mem_ff[new_tail] <= new_wd;
      if (rdy_we) rdy_mem_ff[rdy_tail] <= rdy_wd;
      if (blk_we) blk_mem_ff[blk_tail] <= blk_wd;
      req_ff <= req_in;
      kind_ff <= kind_in;
      status_ff <= status_in;
      rel_id_ff <= rel_id_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         new_head_ff <= '0; new_cnt_ff <= '0;
         rdy_head_ff <= '0; rdy_cnt_ff <= '0;
         blk_head_ff <= '0; blk_cnt_ff <= '0;
         run_ff <= '0; run_valid_ff <= 1'b0;
         free_ff <= MEM_TOTAL_RESET; quantum_ff <= QUANTUM_RESET;
         rel_valid_ff <= 1'b0; adm_ff <= '0;
      end else begin
         new_head_ff <= new_head_in; new_cnt_ff <= new_cnt_in;
         rdy_head_ff <= rdy_head_in; rdy_cnt_ff <= rdy_cnt_in;
         blk_head_ff <= blk_head_in; blk_cnt_ff <= blk_cnt_in;
         run_ff <= run_in; run_valid_ff <= run_valid_in;
         free_ff <= free_in; quantum_ff <= quantum_in;
         rel_valid_ff <= rel_valid_in; adm_ff <= adm_in;
      end
   end

   always_comb begin
      stat.kind          = kind_ff;
      stat.new_full      = (new_cnt_ff >= CNT_BITS'(QUEUE_DEPTH));
      stat.ready_empty   = (rdy_cnt_ff == '0);
      stat.ready_full    = (rdy_cnt_ff >= CNT_BITS'(QUEUE_DEPTH));
      stat.blocked_empty = (blk_cnt_ff == '0);
      stat.blocked_full  = (blk_cnt_ff >= CNT_BITS'(QUEUE_DEPTH));
      stat.running       = run_valid_ff;
      stat.finish        = (run_ff.left <= {8'd0, quantum_ff});
      stat.can_admit     = (new_cnt_ff != '0) && !stat.ready_full &&
                           (new_head.size <= free_ff);
   end

   assign rsp_status         = status_ff;
   assign rsp_running_valid  = run_valid_ff;
   assign rsp_running_id     = run_ff.id;
   assign rsp_released_valid = rel_valid_ff;
   assign rsp_released_id    = rel_id_ff;
   assign rsp_memory_free    = free_ff;
   assign rsp_admitted_count = adm_ff;

endmodule

[sv/round_robin_task_scheduler_top.sv]
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_top
// Five-state round-robin scheduler: new, ready, blocked queues and a run slot.
// ----------------------------------------------------------------------------
// An event is taken when start is high and busy is low. Each event gives
// exactly one result beat: rsp_valid is high for a single cycle and the
// result ports hold the beat's fields only in that cycle; the receiver must
// take it, there is no back-pressure. An event passes through capture,
// execute and result. A create that queues its task, and a timeout that
// releases one, also walk the new queue one head per cycle, moving tasks
// from new to ready until a head that cannot be admitted stops the
// walk. busy stays high from acceptance until the result cycle ends, so one
// event is in flight at a time. Register writes on the csr_ port take
// effect at once and must only be made while busy is low; writing
// memory_total also reloads the free memory count. Queues come out of reset
// empty; queue storage needs no clearing pass.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_task_id,
   input  logic [15:0] req_task_size,
   input  logic [15:0] req_task_time,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic        rsp_running_valid,
   output logic [7:0]  rsp_running_id,
   output logic        rsp_released_valid,
   output logic [7:0]  rsp_released_id,
   output logic [15:0] rsp_memory_free,
   output logic [4:0]  rsp_admitted_count
);
   import rrts_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer: decides each step from the datapath's flags
   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   // queues, run slot, memory count and result registers
   rrts_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_kind           (req_kind),
      .req_task_id        (req_task_id),
      .req_task_size      (req_task_size),
      .req_task_time      (req_task_time),
      .csr_we             (csr_we),
      .csr_addr           (csr_addr),
      .csr_wdata          (csr_wdata),
      .rsp_status         (rsp_status),
      .rsp_running_valid  (rsp_running_valid),
      .rsp_running_id     (rsp_running_id),
      .rsp_released_valid (rsp_released_valid),
      .rsp_released_id    (rsp_released_id),
      .rsp_memory_free    (rsp_memory_free),
      .rsp_admitted_count (rsp_admitted_count)
   );

endmodule

[sv/rrts_checker.sv]
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level checks for the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrts_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [2:0]  rsp_status,
   input logic        rsp_released_valid,
   input logic [7:0]  rsp_released_id,
   input logic [4:0]  rsp_admitted_count
);
   import rrts_pkg::*;

   // accepted event holds busy
   `CHK_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // result beat only ends an event
   `CHK_IMPL(a_beat_in_busy, clock, reset, rsp_valid, busy)
   `CHK_NEXT(a_beat_frees, clock, reset, rsp_valid, !busy && !rsp_valid)
   // a release is a successful timeout
   `CHK_IMPL(a_release_ok, clock, reset, rsp_valid && rsp_released_valid,
             rsp_status == ST_OK)
   `CHK_IMPL(a_admit_bound, clock, reset, rsp_valid,
             (rsp_admitted_count <= 5'(QUEUE_DEPTH)) &&
             (rsp_released_valid || rsp_released_id == 8'd0))

endmodule

bind round_robin_task_scheduler_top rrts_checker u_rrts_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_status         (rsp_status),
   .rsp_released_valid (rsp_released_valid),
   .rsp_released_id    (rsp_released_id),
   .rsp_admitted_count (rsp_admitted_count)
);
